// ===== design/mstk_pkg.sv =====
// Shared types and constants for the Kruskal spanning tree block.
package mstk_pkg;

  localparam int VTX_BITS = 5;
  localparam int CFG_BITS = 6;
  localparam int NV_BITS  = 7;

  // tuser bit positions on the result side
  localparam int USER_VALID_BIT = 0;
  localparam int USER_DROP_BIT  = 1;
  localparam int USER_BITS      = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PINIT,
    ST_SORT_I,
    ST_SORT_K,
    ST_SORT_C,
    ST_SORT_W,
    ST_SCAN_RD,
    ST_SCAN_E,
    ST_FIND_A,
    ST_FIND_B,
    ST_EMIT,
    ST_FIN
  } state_t;

endpackage

// ===== design/mstk_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module mstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/minimum_spanning_tree_kruskal.sv =====
// Input: edges are taken one per cycle while idle; the edge marked last starts the run.
// Run: parent init of all MAX_VERTICES entries, an insertion sort of the stored edges through
// the single edge memory port, then a scan in weight order that finds both roots of each edge
// and emits each chosen edge, stalling while the output is held.
// Throughput: one graph at a time; no edge is taken until the final result is loaded.
// Reset: synchronous, clears fill count, drop flag, output valid; vertex_count returns to 32.
module minimum_spanning_tree_kruskal #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [mstk_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  // s_tdata: src_vertex, dst_vertex, edge_weight, zero fill
  input  logic [((2*mstk_pkg::VTX_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                                                  s_tvalid,
  input  logic                                                  s_tlast,
  output logic                                                  s_tready,
  // m_tdata: tree_src, tree_dst, tree_weight, zero fill
  output logic [((2*mstk_pkg::VTX_BITS+WEIGHT_BITS+7)/8)*8-1:0] m_tdata,
  // m_tuser: tree_valid, dropped_flag
  output logic [mstk_pkg::USER_BITS-1:0]                        m_tuser,
  output logic                                                  m_tvalid,
  output logic                                                  m_tlast,
  input  logic                                                  m_tready
);
  import mstk_pkg::*;

  localparam int EW = 2*VTX_BITS + WEIGHT_BITS;
  localparam int DW = ((EW + 7) / 8) * 8;
  localparam int EA = $clog2(MAX_EDGES);
  localparam int FW = EA + 1;
  localparam int VA = $clog2(MAX_VERTICES);

  state_t state, state_next;

  logic [CFG_BITS-1:0] vertex_count;
  logic [NV_BITS-1:0]  nv;
  logic [FW-1:0]       fill, idx_i, idx_j;
  logic [NV_BITS-1:0]  chosen;
  logic                drop_seen;
  logic [VA-1:0]       pv;
  logic [VA-1:0]       cur, root_a;
  logic [EW-1:0]       key, edge_r, pend;
  logic                pend_v;

  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          p_we;
  logic [VA-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

  logic [VTX_BITS-1:0] in_src, in_dst, er_dst, rd_src, rd_dst;
  logic                in_bad, out_free, out_load;
  logic [USER_BITS-1:0] user_word;

  mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  mstk_ram #(.WIDTH(VA), .DEPTH(MAX_VERTICES)) u_parent_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == ST_EMIT && pend_v) || state == ST_FIN);

  always_comb begin
    user_word = '0;
    user_word[USER_VALID_BIT] = pend_v;
    user_word[USER_DROP_BIT]  = drop_seen;
  end

  // clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      nv = NV_BITS'(1);
    end else if (NV_BITS'(vertex_count) > NV_BITS'(MAX_VERTICES)) begin
      nv = NV_BITS'(MAX_VERTICES);
    end else begin
      nv = NV_BITS'(vertex_count);
    end
  end

  assign in_src = s_tdata[VTX_BITS-1:0];
  assign in_dst = s_tdata[2*VTX_BITS-1:VTX_BITS];
  assign in_bad = (NV_BITS'(in_src) >= nv) || (NV_BITS'(in_dst) >= nv) ||
                  (fill >= FW'(MAX_EDGES));
  assign er_dst = edge_r[2*VTX_BITS-1:VTX_BITS];
  assign rd_src = e_rdata[VTX_BITS-1:0];
  assign rd_dst = e_rdata[2*VTX_BITS-1:VTX_BITS];

  always_comb begin
    state_next = state;
    e_we    = 1'b0;
    e_waddr = fill[EA-1:0];
    e_wdata = s_tdata[EW-1:0];
    e_raddr = idx_i[EA-1:0];
    p_we    = 1'b0;
    p_waddr = pv;
    p_wdata = pv;
    p_raddr = cur;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          e_we = !in_bad;
          if (s_tlast) begin
            state_next = ST_PINIT;
          end
        end
      end
      ST_PINIT: begin
        p_we = 1'b1;
        if (pv == VA'(MAX_VERTICES - 1)) begin
          state_next = ST_SORT_I;
        end
      end
      ST_SORT_I: begin
        e_raddr = idx_i[EA-1:0];
        if (idx_i >= fill) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_SORT_K;
        end
      end
      ST_SORT_K: begin
        e_raddr    = EA'(idx_i - FW'(1));
        state_next = ST_SORT_C;
      end
      ST_SORT_C: begin
        e_we    = 1'b1;
        e_waddr = idx_j[EA-1:0];
        if ($signed(e_rdata[EW-1:2*VTX_BITS]) > $signed(key[EW-1:2*VTX_BITS])) begin
          // shift the larger entry up and keep walking down
          e_wdata = e_rdata;
          e_raddr = EA'(idx_j - FW'(2));
          if (idx_j == FW'(1)) begin
            state_next = ST_SORT_W;
          end
        end else begin
          e_wdata    = key;
          state_next = ST_SORT_I;
        end
      end
      ST_SORT_W: begin
        e_we       = 1'b1;
        e_waddr    = '0;
        e_wdata    = key;
        state_next = ST_SORT_I;
      end
      ST_SCAN_RD: begin
        e_raddr = idx_i[EA-1:0];
        if (idx_i >= fill || chosen + NV_BITS'(1) >= nv) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SCAN_E;
        end
      end
      ST_SCAN_E: begin
        p_raddr = VA'(rd_src);
        if (NV_BITS'(rd_src) >= nv || NV_BITS'(rd_dst) >= nv) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_FIND_A;
        end
      end
      ST_FIND_A: begin
        if (p_rdata == cur) begin
          p_raddr    = VA'(er_dst);
          state_next = ST_FIND_B;
        end else begin
          p_raddr = p_rdata;
        end
      end
      ST_FIND_B: begin
        p_raddr = p_rdata;
        if (p_rdata == cur) begin
          if (root_a != cur) begin
            p_we       = 1'b1;
            p_waddr    = root_a;
            p_wdata    = cur;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_EMIT: begin
        if (!pend_v || out_free) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_BITS'(32);
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drop_seen <= 1'b0;
      pend_v    <= 1'b0;
      m_tvalid  <= 1'b0;
      pv        <= '0;
      chosen    <= '0;
      idx_i     <= '0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          pv    <= '0;
          idx_i <= FW'(1);
          if (s_tvalid) begin
            if (in_bad) begin
              drop_seen <= 1'b1;
            end else begin
              fill <= fill + FW'(1);
            end
          end
        end
        ST_PINIT: begin
          pv <= pv + VA'(1);
        end
        ST_SORT_I: begin
          idx_j <= idx_i;
          if (idx_i >= fill) begin
            idx_i  <= '0;
            chosen <= '0;
            pend_v <= 1'b0;
          end
        end
        ST_SORT_K: begin
          key <= e_rdata;
        end
        ST_SORT_C: begin
          if ($signed(e_rdata[EW-1:2*VTX_BITS]) > $signed(key[EW-1:2*VTX_BITS])) begin
            idx_j <= idx_j - FW'(1);
          end else begin
            idx_i <= idx_i + FW'(1);
          end
        end
        ST_SORT_W: begin
          idx_i <= idx_i + FW'(1);
        end
        ST_SCAN_E: begin
          edge_r <= e_rdata;
          cur    <= VA'(rd_src);
          idx_i  <= idx_i + FW'(1);
        end
        ST_FIND_A: begin
          if (p_rdata == cur) begin
            root_a <= cur;
            cur    <= VA'(er_dst);
          end else begin
            cur <= p_rdata;
          end
        end
        ST_FIND_B: begin
          if (p_rdata == cur) begin
            if (root_a != cur) begin
              chosen <= chosen + NV_BITS'(1);
            end
          end else begin
            cur <= p_rdata;
          end
        end
        ST_EMIT: begin
          if (!pend_v) begin
            pend   <= edge_r;
            pend_v <= 1'b1;
          end else if (out_free) begin
            // hand the held edge on; the new one waits to learn if it is the final one
            m_tvalid <= 1'b1;
            m_tdata  <= DW'(pend);
            m_tuser  <= user_word;
            m_tlast  <= 1'b0;
            pend     <= edge_r;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= pend_v ? DW'(pend) : '0;
            m_tuser   <= user_word;
            m_tlast   <= 1'b1;
            fill      <= '0;
            drop_seen <= 1'b0;
            chosen    <= '0;
            pend_v    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/minimum_spanning_tree_kruskal_tb.sv =====
// Testbench for the Kruskal spanning tree block: self-checking with a built-in tree predictor.
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal_tb;
  import mstk_pkg::*;

  localparam int MAXV = 32;
  localparam int MAXE = 64;
  localparam int DW = ((2*VTX_BITS+16+7)/8)*8;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] dst;
    logic signed [15:0] wt;
    logic vld;
    logic drop;
    logic last;
  } tree_edge_t;

  logic clk = 0;
  logic rst = 1;
  logic [5:0] cfg_data = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [DW-1:0] s_tdata = '0;
  logic s_tvalid = 0, s_tlast = 0, s_tready;
  logic [DW-1:0] m_tdata;
  logic [USER_BITS-1:0] m_tuser;
  logic m_tvalid, m_tlast;
  logic m_tready = 0;

  minimum_spanning_tree_kruskal u_top (
    .clk(clk), .rst(rst),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tlast(s_tlast), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tlast(m_tlast),
    .m_tready(m_tready)
  );

  // predictor state
  logic [4:0] gs_src [MAXE];
  logic [4:0] gs_dst [MAXE];
  logic signed [15:0] gs_wt [MAXE];
  int gs_fill = 0;
  bit gs_drop = 0;
  logic [5:0] nv_reg = 6'd32;
  tree_edge_t tree_q[$];
  int errors = 0;
  int hold_off = 0;
  longint cycles = 0;

  initial forever #1 clk = ~clk;

  function automatic int eff_nv();
    if (nv_reg == 0) return 1;
    if (nv_reg > MAXV) return MAXV;
    return int'(nv_reg);
  endfunction

  // Walk to the root and compress the path.
  function automatic int find_root(ref int par[MAXV], input int v);
    int r;
    int nx;
    r = v;
    while (par[r] != r) r = par[r];
    while (v != r) begin
      nx = par[v];
      par[v] = r;
      v = nx;
    end
    return r;
  endfunction

  task automatic predict_edge(input logic [4:0] s, input logic [4:0] d,
                              input logic signed [15:0] w, input bit lst);
    int nv, i, j, x, y, n;
    int par[MAXV];
    logic [4:0] ks, kd;
    logic signed [15:0] kw;
    tree_edge_t r;
    nv = eff_nv();
    if (s >= nv || d >= nv || gs_fill >= MAXE) gs_drop = 1;
    else begin
      gs_src[gs_fill] = s; gs_dst[gs_fill] = d; gs_wt[gs_fill] = w;
      gs_fill++;
    end
    if (!lst) return;
    // stable insertion sort by weight
    for (i = 1; i < gs_fill; i++) begin
      ks = gs_src[i]; kd = gs_dst[i]; kw = gs_wt[i];
      j = i;
      while (j > 0 && gs_wt[j-1] > kw) begin
        gs_src[j] = gs_src[j-1]; gs_dst[j] = gs_dst[j-1]; gs_wt[j] = gs_wt[j-1];
        j--;
      end
      gs_src[j] = ks; gs_dst[j] = kd; gs_wt[j] = kw;
    end
    for (i = 0; i < MAXV; i++) par[i] = i;
    n = 0;
    for (i = 0; i < gs_fill && n + 1 < nv; i++) begin
      if (gs_src[i] >= nv || gs_dst[i] >= nv) continue;
      x = find_root(par, gs_src[i]);
      y = find_root(par, gs_dst[i]);
      if (x != y) begin
        r = '{gs_src[i], gs_dst[i], gs_wt[i], 1'b1, gs_drop, 1'b0};
        tree_q.push_back(r);
        par[x] = y;
        n++;
      end
    end
    if (n == 0) tree_q.push_back('{5'd0, 5'd0, 16'sd0, 1'b0, gs_drop, 1'b1});
    else tree_q[$].last = 1;
    gs_fill = 0;
    gs_drop = 0;
  endtask

  // Leaves tvalid high after the transfer so edges can follow back to back.
  task automatic send_edge(input logic [4:0] s, input logic [4:0] d,
                           input logic signed [15:0] w, input bit lst, input bit gaps);
    int g;
    g = 0;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
    end
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tdata <= {{(DW-26){1'b0}}, w, d, s};
    s_tlast <= lst;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_edge(s, d, w, lst);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (tree_q.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [5:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    nv_reg = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_graph(input int n_edges, input int span, input bit gaps);
    int k;
    logic signed [15:0] w;
    for (k = 0; k < n_edges; k++) begin
      w = ($urandom_range(0, 3) == 0) ? $signed(16'($urandom)) :
          $signed(16'($urandom_range(0, 7)) - 16'sd3);
      send_edge(5'($urandom_range(0, span - 1)), 5'($urandom_range(0, span - 1)),
                w, k == n_edges - 1, gaps);
    end
  endtask

  task automatic test_directed();
    // extremes, self loop, tie order, out of range vertex
    send_edge(5'd0, 5'd31, 16'sh7fff, 0, 0);
    send_edge(5'd31, 5'd0, -16'sd32768, 0, 0);
    send_edge(5'd3, 5'd3, -16'sd5, 0, 0);
    send_edge(5'd1, 5'd2, 16'sd7, 0, 0);
    send_edge(5'd2, 5'd1, 16'sd7, 0, 0);
    send_edge(5'd21, 5'd10, 16'sd0, 1, 0);
    // lone self loop: empty tree
    send_edge(5'd4, 5'd4, 16'sd1, 1, 0);
    write_vertex_count(6'd4);
    send_edge(5'd5, 5'd1, 16'sd2, 0, 0);
    send_edge(5'd0, 5'd1, 16'sd2, 0, 0);
    send_edge(5'd2, 5'd3, -16'sd1, 1, 0);
  endtask

  task automatic test_lowered_count();
    // store edges at 32, then shrink so some are skipped
    write_vertex_count(6'd32);
    send_edge(5'd20, 5'd1, 16'sd1, 0, 0);
    send_edge(5'd0, 5'd1, 16'sd3, 0, 0);
    write_vertex_count(6'd3);
    send_edge(5'd1, 5'd2, 16'sd2, 1, 0);
    write_vertex_count(6'd0);
    send_edge(5'd0, 5'd0, 16'sd0, 0, 0);
    send_edge(5'd1, 5'd0, 16'sd9, 1, 0);
    write_vertex_count(6'd63);
    send_edge(5'd31, 5'd30, 16'sd4, 1, 0);
  endtask

  task automatic test_overflow();
    int k;
    write_vertex_count(6'd32);
    for (k = 0; k < 70; k++)
      send_edge(5'($urandom), 5'($urandom), $signed(16'($urandom)), k == 69, 0);
  endtask

  task automatic test_random();
    int sent, n, span;
    logic [5:0] nvv;
    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(0, 5) == 0) begin
        nvv = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
        write_vertex_count(nvv);
      end
      n = $urandom_range(1, 12);
      span = eff_nv();
      if ($urandom_range(0, 5) == 0 && span < MAXV) span = span + 1;
      send_graph(n, span, 1);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    int k;
    write_vertex_count(6'd32);
    @(posedge clk);
    hold_off = 400;
    @(negedge clk);
    for (k = 0; k < 3; k++) send_graph(10, 32, 0);
    drain();
  endtask

  // receiver readiness
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 19) == 0) begin
      hold_off <= $urandom_range(5, 40);
      m_tready <= 0;
    end else m_tready <= ($urandom_range(0, 3) != 0) || cycles[9];
  end

  // result check
  always @(posedge clk) begin
    tree_edge_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (tree_q.size() == 0) begin
        $display("%0t unexpected result tdata=%h tuser=%b last=%b", $time, m_tdata, m_tuser,
                 m_tlast);
        errors++;
      end else begin
        e = tree_q.pop_front();
        if (m_tdata[4:0] !== e.src || m_tdata[9:5] !== e.dst || m_tdata[25:10] !== e.wt ||
            m_tdata[DW-1:26] !== '0 || m_tuser[USER_VALID_BIT] !== e.vld ||
            m_tuser[USER_DROP_BIT] !== e.drop || m_tlast !== e.last) begin
          $display("%0t mismatch expected src=%0d dst=%0d wt=%0d vld=%b drop=%b last=%b",
                   $time, e.src, e.dst, e.wt, e.vld, e.drop, e.last);
          $display("%0t          actual src=%0d dst=%0d wt=%0d vld=%b drop=%b last=%b",
                   $time, m_tdata[4:0], m_tdata[9:5], $signed(m_tdata[25:10]),
                   m_tuser[USER_VALID_BIT], m_tuser[USER_DROP_BIT], m_tlast);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_lowered_count();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && tree_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
